// ----- hw/rtl/u8vd_pkg.sv -----
// Shared types and constants for the UTF-8 validating decoder.
// Used by the channel interfaces, the controller, the datapath and the top level.
package u8vd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CP_W    = 21;
	// The buffer holds up to three pending bytes plus the byte just taken.
	localparam int unsigned BUF_N   = 4;
	localparam int unsigned CNT_W   = 3;

	localparam logic [CP_W-1:0] CP_MIN_2  = 21'h000080;
	localparam logic [CP_W-1:0] CP_MIN_3  = 21'h000800;
	localparam logic [CP_W-1:0] CP_MIN_4  = 21'h010000;
	localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;

	localparam logic STATUS_VALID   = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;     // take the offered byte into the buffer
		logic consume;  // emit the decoded result and drop its bytes
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic empty;      // no bytes buffered
		logic wait_more;  // head sequence incomplete and stream not ended
		logic out_free;   // output register can take a result this cycle
	} stat_t;

endpackage

// ----- hw/rtl/u8vd_byte_if.sv -----
// Input channel of the UTF-8 decoder: one stream byte per item.
// Depends on u8vd_pkg for the byte width.
interface u8vd_byte_if;
	logic                        valid;
	logic                        ready;
	logic [u8vd_pkg::BYTE_W-1:0] data_byte;
	logic                        final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

// ----- hw/rtl/u8vd_cp_if.sv -----
// Output channel of the UTF-8 decoder: one decoded code point per item.
// Depends on u8vd_pkg for the code point width.
interface u8vd_cp_if;
	logic                      valid;
	logic                      ready;
	logic [u8vd_pkg::CP_W-1:0] code_point;
	logic                      status;
	logic                      stream_end;

	modport source (output valid, output code_point, output status, output stream_end,
		input ready);
	modport sink (input valid, input code_point, input status, input stream_end,
		output ready);
endinterface

// ----- hw/rtl/u8vd_ctrl.sv -----
// Controller of the UTF-8 decoder: accepts bytes and steps the scan of the buffer.
// Depends on u8vd_pkg and u8vd_byte_if.
module u8vd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	u8vd_byte_if.sink           byte_ch,
	input  u8vd_pkg::stat_t     stat,
	output u8vd_pkg::cmd_t      cmd
);

	u8vd_pkg::state_t state_q;
	u8vd_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= u8vd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			u8vd_pkg::ST_IDLE: begin
				if (byte_ch.valid) begin
					state_d = u8vd_pkg::ST_SCAN;
				end
			end
			u8vd_pkg::ST_SCAN: begin
				if (stat.empty || stat.wait_more) begin
					state_d = u8vd_pkg::ST_IDLE;
				end
			end
			default: state_d = u8vd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		byte_ch.ready = 1'b0;
		cmd.load      = 1'b0;
		cmd.consume   = 1'b0;
		unique case (state_q)
			u8vd_pkg::ST_IDLE: begin
				byte_ch.ready = 1'b1;
				cmd.load      = byte_ch.valid;
			end
			u8vd_pkg::ST_SCAN: begin
				// One sequence leaves the buffer per cycle, when the output has room.
				cmd.consume = !stat.empty && !stat.wait_more && stat.out_free;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

endmodule

// ----- hw/rtl/u8vd_datapath.sv -----
// Datapath of the UTF-8 decoder: byte buffer, head-sequence decode and output register.
// Depends on u8vd_pkg and u8vd_cp_if.
module u8vd_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [u8vd_pkg::BYTE_W-1:0] data_byte,
	input  logic                        final_byte,
	input  u8vd_pkg::cmd_t              cmd,
	output u8vd_pkg::stat_t             stat,
	u8vd_cp_if.source                   cp_ch
);

	logic [u8vd_pkg::BUF_N-1:0][u8vd_pkg::BYTE_W-1:0] buf_q;
	logic [u8vd_pkg::BUF_N-1:0][u8vd_pkg::BYTE_W-1:0] buf_shifted;
	logic [u8vd_pkg::CNT_W-1:0]  cnt_q;
	logic                        last_q;

	logic                        out_valid_q;
	logic [u8vd_pkg::CP_W-1:0]   out_cp_q;
	logic                        out_status_q;
	logic                        out_end_q;

	logic [u8vd_pkg::BYTE_W-1:0] lead;
	logic [u8vd_pkg::CNT_W-1:0]  seq_len;
	logic                        is_ascii;
	logic                        lead_bad;
	logic                        avail;
	logic                        cont_ok;
	logic                        range_bad;
	logic [u8vd_pkg::CP_W-1:0]   cp_seq;
	logic [u8vd_pkg::CP_W-1:0]   res_cp;
	logic                        res_bad;
	logic [u8vd_pkg::CNT_W-1:0]  adv;

	assign lead = buf_q[0];

	always_comb begin
		is_ascii = 1'b0;
		lead_bad = 1'b0;
		seq_len  = 3'd1;
		if (lead[7] == 1'b0) begin
			is_ascii = 1'b1;
		end else if (lead[7:5] == 3'b110) begin
			seq_len = 3'd2;
		end else if (lead[7:4] == 4'b1110) begin
			seq_len = 3'd3;
		end else if (lead[7:3] == 5'b11110) begin
			seq_len = 3'd4;
		end else begin
			lead_bad = 1'b1;
		end
	end

	assign avail = (cnt_q >= seq_len);

	always_comb begin
		cont_ok = 1'b1;
		for (int i = 1; i < u8vd_pkg::BUF_N; i++) begin
			if ((i < int'(seq_len)) && (buf_q[i][7:6] != 2'b10)) begin
				cont_ok = 1'b0;
			end
		end
	end

	always_comb begin
		cp_seq    = '0;
		range_bad = 1'b0;
		case (seq_len)
			3'd2: begin
				cp_seq    = {10'd0, lead[4:0], buf_q[1][5:0]};
				range_bad = (cp_seq < u8vd_pkg::CP_MIN_2);
			end
			3'd3: begin
				cp_seq    = {5'd0, lead[3:0], buf_q[1][5:0], buf_q[2][5:0]};
				range_bad = (cp_seq < u8vd_pkg::CP_MIN_3)
					|| ((cp_seq >= u8vd_pkg::SURR_LO) && (cp_seq <= u8vd_pkg::SURR_HI));
			end
			3'd4: begin
				cp_seq    = {lead[2:0], buf_q[1][5:0], buf_q[2][5:0], buf_q[3][5:0]};
				range_bad = (cp_seq < u8vd_pkg::CP_MIN_4) || (cp_seq > u8vd_pkg::CP_MAX);
			end
			default: begin
				cp_seq    = '0;
				range_bad = 1'b0;
			end
		endcase
	end

	// An invalid sequence of any kind drops only its lead byte.
	always_comb begin
		res_cp  = '0;
		res_bad = u8vd_pkg::STATUS_INVALID;
		adv     = 3'd1;
		if (is_ascii) begin
			res_cp  = {13'd0, lead};
			res_bad = u8vd_pkg::STATUS_VALID;
		end else if (!lead_bad && avail && cont_ok && !range_bad) begin
			res_cp  = cp_seq;
			res_bad = u8vd_pkg::STATUS_VALID;
			adv     = seq_len;
		end
	end

	assign buf_shifted = buf_q >> {adv, 3'b000};

	assign stat.empty     = (cnt_q == '0);
	assign stat.wait_more = (cnt_q != '0) && !avail && !last_q;
	assign stat.out_free  = !out_valid_q || cp_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q  <= cnt_q + 3'd1;
			last_q <= final_byte;
		end else if (cmd.consume) begin
			cnt_q  <= cnt_q - adv;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			buf_q[cnt_q[1:0]] <= data_byte;
		end else if (cmd.consume) begin
			buf_q <= buf_shifted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.consume) begin
			out_valid_q <= 1'b1;
		end else if (cp_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.consume) begin
			out_cp_q     <= res_cp;
			out_status_q <= res_bad;
			// The final byte drains everything, so the result that empties the buffer is last.
			out_end_q    <= last_q && (cnt_q == adv);
		end
	end

	assign cp_ch.valid      = out_valid_q;
	assign cp_ch.code_point = out_cp_q;
	assign cp_ch.status     = out_status_q;
	assign cp_ch.stream_end = out_end_q;

endmodule

// ----- hw/rtl/utf8_validating_decoder_core.sv -----
// Strict UTF-8 decoder: one byte in per item, zero to four code points out per byte.
// A byte is taken while the controller is idle; a single decode slice then resolves
// one sequence per cycle at the head of a four-byte buffer while the output has room,
// and no new byte is taken until no decodable sequence is left. Invalid sequences
// give status 1 with code point 0 and skip only their lead byte; the final byte
// drains all pending bytes and its last result carries stream_end. Depends on
// u8vd_pkg, u8vd_byte_if, u8vd_cp_if, u8vd_ctrl and u8vd_datapath.
module utf8_validating_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	u8vd_byte_if.sink   byte_ch,
	u8vd_cp_if.source   cp_ch
);

	u8vd_pkg::cmd_t  cmd;
	u8vd_pkg::stat_t stat;

	u8vd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.stat    (stat),
		.cmd     (cmd)
	);

	u8vd_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (byte_ch.data_byte),
		.final_byte (byte_ch.final_byte),
		.cmd        (cmd),
		.stat       (stat),
		.cp_ch      (cp_ch)
	);

	// While waiting for a byte, the buffer is empty or holds only an incomplete sequence.
	a_idle_settled: assert property (@(posedge clk) disable iff (!arst_n)
		byte_ch.ready |-> (stat.empty || stat.wait_more))
		else $error("decoder idle with a decodable sequence buffered");

	// A result is produced only when the output register can take it.
	a_consume_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.consume |-> (stat.out_free && !cmd.load))
		else $error("result produced without output room");

	// Invalid results carry a zero code point.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cp_ch.valid && cp_ch.status) |-> (cp_ch.code_point == '0))
		else $error("invalid result with nonzero code point");

endmodule

// ----- tb/utf8_validating_decoder_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench for utf8_validating_decoder_core: drives byte streams and checks each code point.
// Depends on u8vd_pkg, u8vd_byte_if, u8vd_cp_if and the decoder RTL.
module utf8_validating_decoder_core_tb;

	localparam int unsigned LIMIT_CYCLES = 1000000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned HOLD_CYCLES  = 300;

	typedef struct packed {
		logic [u8vd_pkg::CP_W-1:0] cp;
		logic                      status;
		logic                      stream_end;
	} cp_item_t;

	typedef enum int unsigned {
		UNIT_SCALAR,
		UNIT_NOISE,
		UNIT_TRUNC,
		UNIT_BAD_CONT,
		UNIT_OVERLONG,
		UNIT_SURROGATE,
		UNIT_ABOVE
	} unit_kind_t;

	logic clk;
	logic arst_n;

	u8vd_byte_if byte_ch();
	u8vd_cp_if   cp_ch();

	utf8_validating_decoder_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.byte_ch(byte_ch),
		.cp_ch  (cp_ch)
	);

	cp_item_t    expected_cps[$];
	logic [7:0]  held_bytes[3];
	int unsigned held_count;
	logic [7:0]  stream_bytes[$];
	logic [7:0]  unit_bytes[$];
	int unsigned mismatch_count;
	int unsigned cycle_count;
	int unsigned rx_stall;
	int unsigned rx_hold_req;
	bit          tx_idle_on;
	bit          rx_idle_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("utf8_validating_decoder_core verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		$display("MISMATCH at %0t: %s got 0x%0h, want 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Decodes the held bytes plus the new byte exactly as the block must, and queues
	// the code points that this byte releases.
	function automatic void predict_decode(input logic [7:0] b, input logic fin);
		logic [7:0]                win[4];
		cp_item_t                  res[4];
		logic [7:0]                b0;
		logic [u8vd_pkg::CP_W-1:0] val;
		logic [u8vd_pkg::CP_W-1:0] lo;
		int unsigned               n;
		int unsigned               pos;
		int unsigned               len;
		int unsigned               k;
		int unsigned               i;
		bit                        bad;
		bit                        stall;
		n = held_count;
		for (i = 0; i < n; i++)
			win[i] = held_bytes[i];
		win[n] = b;
		n++;
		pos   = 0;
		k     = 0;
		stall = 1'b0;
		while (pos < n && !stall) begin
			b0  = win[pos];
			bad = 1'b0;
			len = 1;
			val = '0;
			lo  = '0;
			if (b0 < 8'h80) begin
				val = u8vd_pkg::CP_W'(b0);
			end else if ((b0 & 8'hE0) == 8'hC0) begin
				len = 2; val = u8vd_pkg::CP_W'(b0 & 8'h1F); lo = u8vd_pkg::CP_MIN_2;
			end else if ((b0 & 8'hF0) == 8'hE0) begin
				len = 3; val = u8vd_pkg::CP_W'(b0 & 8'h0F); lo = u8vd_pkg::CP_MIN_3;
			end else if ((b0 & 8'hF8) == 8'hF0) begin
				len = 4; val = u8vd_pkg::CP_W'(b0 & 8'h07); lo = u8vd_pkg::CP_MIN_4;
			end else begin
				bad = 1'b1;
			end
			if (!bad && len > 1) begin
				if (n - pos < len) begin
					// A short sequence waits for more bytes unless the stream ends here.
					if (fin)
						bad = 1'b1;
					else
						stall = 1'b1;
				end else begin
					for (i = 1; i < len; i++) begin
						if (!bad) begin
							if (win[pos+i][7:6] != 2'b10)
								bad = 1'b1;
							else
								val = (val << 6) | u8vd_pkg::CP_W'(win[pos+i][5:0]);
						end
					end
					if (!bad && (val < lo ||
						(val >= u8vd_pkg::SURR_LO && val <= u8vd_pkg::SURR_HI) ||
						val > u8vd_pkg::CP_MAX))
						bad = 1'b1;
				end
			end
			if (!stall) begin
				if (bad) begin
					res[k] = '{cp: '0, status: u8vd_pkg::STATUS_INVALID, stream_end: 1'b0};
					pos++;
				end else begin
					res[k] = '{cp: val, status: u8vd_pkg::STATUS_VALID, stream_end: 1'b0};
					pos += len;
				end
				k++;
			end
		end
		if (fin) begin
			held_count = 0;
			if (k > 0)
				res[k-1].stream_end = 1'b1;
		end else begin
			held_count = n - pos;
			for (i = 0; i < held_count; i++)
				held_bytes[i] = win[pos+i];
		end
		for (i = 0; i < k; i++)
			expected_cps.push_back(res[i]);
	endfunction

	always @(posedge clk) begin : result_check
		cp_item_t want;
		if (arst_n && cp_ch.valid && cp_ch.ready) begin
			if (expected_cps.size() == 0) begin
				report_mismatch("code point with nothing outstanding",
					32'(cp_ch.code_point), 0);
			end else begin
				want = expected_cps.pop_front();
				if (cp_ch.code_point !== want.cp)
					report_mismatch("code_point", 32'(cp_ch.code_point), 32'(want.cp));
				if (cp_ch.status !== want.status)
					report_mismatch("status", 32'(cp_ch.status), 32'(want.status));
				if (cp_ch.stream_end !== want.stream_end)
					report_mismatch("stream_end", 32'(cp_ch.stream_end),
						32'(want.stream_end));
			end
		end
		if (arst_n && byte_ch.valid && byte_ch.ready)
			predict_decode(byte_ch.data_byte, byte_ch.final_byte);
	end

	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(12, 40);
		return $urandom_range(1, 3);
	endfunction

	// Receiver: random stalls, plus one long hold-off when a test asks for it.
	initial begin
		cp_ch.ready = 1'b0;
		rx_stall    = 0;
		forever begin
			@(negedge clk);
			if (rx_stall > 0) begin
				rx_stall--;
				cp_ch.ready <= 1'b0;
			end else if (rx_hold_req > 0) begin
				rx_stall    = rx_hold_req - 1;
				rx_hold_req = 0;
				cp_ch.ready <= 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				rx_stall = pick_gap() - 1;
				cp_ch.ready <= 1'b0;
			end else begin
				cp_ch.ready <= 1'b1;
			end
		end
	end

	// The caller leaves valid high after an item, so a following item with no idle gap
	// drives new data on the next falling edge without lowering it first.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int unsigned gap;
		gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		@(negedge clk);
		if (gap != 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_ch.valid      <= 1'b1;
		byte_ch.data_byte  <= b;
		byte_ch.final_byte <= fin;
		do @(posedge clk); while (!byte_ch.ready);
	endtask

	task automatic send_stream(input bit fin_last);
		int unsigned i;
		for (i = 0; i < stream_bytes.size(); i++)
			send_byte(stream_bytes[i], fin_last && (i == stream_bytes.size() - 1));
	endtask

	// Encodes a value at a forced length, so overlong and out-of-range forms come
	// from the same code as legal ones.
	function automatic void push_encoded(input logic [20:0] cp, input int unsigned len);
		case (len)
			1: unit_bytes.push_back({1'b0, cp[6:0]});
			2: begin
				unit_bytes.push_back({3'b110, cp[10:6]});
				unit_bytes.push_back({2'b10, cp[5:0]});
			end
			3: begin
				unit_bytes.push_back({4'b1110, cp[15:12]});
				unit_bytes.push_back({2'b10, cp[11:6]});
				unit_bytes.push_back({2'b10, cp[5:0]});
			end
			default: begin
				unit_bytes.push_back({5'b11110, cp[20:18]});
				unit_bytes.push_back({2'b10, cp[17:12]});
				unit_bytes.push_back({2'b10, cp[11:6]});
				unit_bytes.push_back({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	function automatic int unsigned legal_scalar(input int unsigned len);
		int unsigned cp;
		case (len)
			1: cp = $urandom_range(0, 'h7F);
			2: cp = $urandom_range('h80, 'h7FF);
			3: begin
				cp = $urandom_range('h800, 'hF7FF);
				if (cp >= 'hD800)
					cp += 'h800;
			end
			default: cp = $urandom_range('h10000, 'h10FFFF);
		endcase
		return cp;
	endfunction

	// Three units in four are legal scalars; the rest are noise or broken forms.
	function automatic void build_unit();
		unit_kind_t  kind;
		int unsigned len;
		int unsigned k;
		logic [7:0]  b;
		unit_bytes.delete();
		if ($urandom_range(0, 3) != 0)
			kind = UNIT_SCALAR;
		else
			kind = unit_kind_t'($urandom_range(UNIT_NOISE, UNIT_ABOVE));
		len = $urandom_range(2, 4);
		case (kind)
			UNIT_SCALAR: begin
				len = $urandom_range(1, 4);
				push_encoded(21'(legal_scalar(len)), len);
			end
			UNIT_NOISE: unit_bytes.push_back(8'($urandom_range(0, 255)));
			UNIT_TRUNC: begin
				push_encoded(21'(legal_scalar(len)), len);
				k = $urandom_range(1, len - 1);
				repeat (k) void'(unit_bytes.pop_back());
			end
			UNIT_BAD_CONT: begin
				push_encoded(21'(legal_scalar(len)), len);
				b = 8'($urandom_range(0, 255));
				if (b[7:6] == 2'b10)
					b[6] = 1'b1;
				unit_bytes[$urandom_range(1, len - 1)] = b;
			end
			UNIT_OVERLONG: begin
				case (len)
					2: push_encoded(21'($urandom_range(0, 'h7F)), 2);
					3: push_encoded(21'($urandom_range(0, 'h7FF)), 3);
					default: push_encoded(21'($urandom_range(0, 'hFFFF)), 4);
				endcase
			end
			UNIT_SURROGATE: push_encoded(21'($urandom_range('hD800, 'hDFFF)), 3);
			default: push_encoded(21'($urandom_range('h110000, 'h1FFFFF)), 4);
		endcase
	endfunction

	task automatic test_valid_forms();
		// Smallest and largest scalars, shortest and longest legal encodings.
		stream_bytes = {8'h00, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF,
			8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h7F};
		send_stream(1'b1);
	endtask

	task automatic test_invalid_forms();
		// Bad lead, bad continuation, overlong, surrogate and above-range forms.
		// The skipped leads leave stray continuation bytes to be rejected one by one.
		stream_bytes = {8'hFF, 8'hC3, 8'h41, 8'hC0, 8'hAF, 8'hED, 8'hA0, 8'h80,
			8'hF4, 8'h90, 8'h80, 8'h80};
		send_stream(1'b0);
	endtask

	task automatic test_truncation();
		stream_bytes = {8'hE2, 8'h82};
		send_stream(1'b1);
	endtask

	task automatic test_random_streams(input int unsigned n_items);
		int unsigned sent;
		int unsigned units;
		sent = 0;
		while (sent < n_items) begin
			stream_bytes.delete();
			units = $urandom_range(1, 8);
			repeat (units) begin
				build_unit();
				foreach (unit_bytes[i])
					stream_bytes.push_back(unit_bytes[i]);
			end
			send_stream($urandom_range(0, 4) != 0);
			sent += stream_bytes.size();
		end
	endtask

	task automatic test_backpressure();
		stream_bytes.delete();
		while (stream_bytes.size() < 40) begin
			build_unit();
			foreach (unit_bytes[i])
				stream_bytes.push_back(unit_bytes[i]);
		end
		tx_idle_on  = 1'b0;
		rx_idle_on  = 1'b0;
		rx_hold_req = HOLD_CYCLES;
		send_stream(1'b1);
	endtask

	task automatic wait_for_drain();
		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (expected_cps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n             = 1'b0;
		byte_ch.valid      = 1'b0;
		byte_ch.data_byte  = '0;
		byte_ch.final_byte = 1'b0;
		held_count         = 0;
		mismatch_count     = 0;
		cycle_count        = 0;
		rx_hold_req        = 0;
		tx_idle_on         = 1'b0;
		rx_idle_on         = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_valid_forms();
		test_invalid_forms();
		test_truncation();
		test_random_streams(80);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		test_random_streams(150);
		test_backpressure();
		wait_for_drain();

		if (mismatch_count == 0)
			$display("utf8_validating_decoder_core verification clean");
		else
			$display("utf8_validating_decoder_core verification failed");
		$finish;
	end
endmodule
